// ===== src/mde_pkg.sv =====
package mde_pkg;

    localparam int FRACTION_BITS_DEF  = 18;
    localparam int MAX_ITERATIONS_DEF = 64;

    localparam int POINT_W    = 24;
    localparam int SCALE_W    = 22;
    localparam int LIMIT_W    = 7;
    localparam int DIST_W     = 31;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 22;
    localparam int SQRT_STEPS = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_FOLD_SCALE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT = 2'd1;

    localparam logic signed [SCALE_W-1:0] FOLD_SCALE_RESET = -22'sd471859;
    localparam logic [LIMIT_W-1:0] ITERATION_LIMIT_RESET   = 7'd12;

    localparam logic [63:0] DIST_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM61    = 64'h2000_0000_0000_0000;
    localparam logic [63:0] DR_MAX   = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic signed [POINT_W-1:0] point_z;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              escaped;
        logic              derivative_saturated;
    } out_beat_t;

    typedef enum logic [3:0] {
        OP_SQX, OP_SQY, OP_SQZ,
        OP_TX, OP_TY, OP_TZ, OP_TDR,
        OP_SX, OP_SY, OP_SZ, OP_SDR,
        OP_EQX, OP_EQY, OP_EQZ
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    fold;
        logic    quad;
        logic    mul_start;
        logic    mul_wb;
        mul_op_t op;
        logic    div_start;
        logic    div_dist;
        logic    t_wb;
        logic    esc_set;
        logic    s_dec;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic lt_quarter;
        logic lt_one;
        logic gt_esc;
        logic shift_more;
    } sts_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

// ===== src/mde_mul.sv =====
module mde_mul #(
    parameter int FRACTION_BITS = mde_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] res
);
    import mde_pkg::*;

    // 64x64 product from four 32x32 partial products, one per cycle
    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic         sat;

    assign pa    = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign pb    = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp    = pa * pb;
    assign pp_sh = {64'd0, pp} << (7'(cnt_reg[0]) * 7'd32 + 7'(cnt_reg[1]) * 7'd32);

    assign sat  = |(acc_reg >> (64 + FRACTION_BITS));
    assign res  = sat ? '1 : acc_reg[FRACTION_BITS +: 64];
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= acc_reg + pp_sh;
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/mde_div.sv =====
module mde_div #(
    parameter int FRACTION_BITS = mde_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo,
    output logic        over
);
    import mde_pkg::*;

    // restoring division of num * 2^FRACTION_BITS by den, one bit a cycle
    localparam int NB   = 64 + FRACTION_BITS;
    localparam int CNTW = $clog2(NB);

    logic [NB-1:0]   sh_reg;
    logic [63:0]     den_reg, rem_reg, q_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, done_reg, over_reg;
    logic [64:0]     rem_sh, rem_sub;
    logic            ge;
    logic [63:0]     q_next;

    assign rem_sh  = {rem_reg, sh_reg[NB-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign q_next  = {q_reg[62:0], ge};

    assign done = done_reg;
    assign quo  = q_reg;
    assign over = over_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                sh_reg   <= {num, {FRACTION_BITS{1'b0}}};
                den_reg  <= den;
                rem_reg  <= '0;
                q_reg    <= '0;
                over_reg <= 1'b0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? rem_sub[63:0] : rem_sh[63:0];
                q_reg    <= q_next;
                over_reg <= over_reg | (q_next > DIST_MAX);
                sh_reg   <= sh_reg << 1;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NB - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/mde_dp.sv =====
module mde_dp #(
    parameter int FRACTION_BITS = mde_pkg::FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mde_pkg::cmd_t                       cmd,
    output mde_pkg::sts_t                       sts,
    input  mde_pkg::in_beat_t                   in_beat,
    input  logic signed [mde_pkg::SCALE_W-1:0]  fold_scale,
    output mde_pkg::out_beat_t                  out_beat
);
    import mde_pkg::*;

    localparam int SW = $clog2(FRACTION_BITS + 1);
    localparam logic [63:0] ONE     = 64'(1) << FRACTION_BITS;
    localparam logic [63:0] QUARTER = 64'(1) << (FRACTION_BITS - 2);
    localparam logic [63:0] ESC_LIM = 64'(1000000) << FRACTION_BITS;
    localparam logic signed [63:0] ONE_S = $signed(ONE);

    logic signed [63:0] cx_reg, cy_reg, cz_reg, x_reg, y_reg, z_reg, scale_reg;
    logic [63:0] dr_reg, ascale_reg, r2_reg, t_reg;
    logic        sat_reg, esc_reg;
    logic [SW-1:0] s_reg;
    logic [63:0] sq_v_reg, sq_res_reg, sq_bit_reg, sq_sum;
    out_beat_t   out_reg;

    logic [63:0] mul_a, mul_b, mul_res, m, div_num, div_den, div_q, dr4, sdr_sum;
    logic        mul_done, div_done, div_over;
    logic signed [63:0] m_s;

    function automatic logic signed [63:0] box(input logic signed [63:0] v);
        if (v > ONE_S) return (ONE_S <<< 1) - v;
        if (v < -ONE_S) return -(ONE_S <<< 1) - v;
        return v;
    endfunction

    mde_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .res(mul_res)
    );

    mde_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(div_num), .den(div_den), .done(div_done), .quo(div_q), .over(div_over)
    );

    always_comb begin
        mul_a = mag64(x_reg);
        mul_b = mag64(x_reg);
        case (cmd.op) inside
            OP_SQY, OP_EQY: begin mul_a = mag64(y_reg); mul_b = mag64(y_reg); end
            OP_SQZ, OP_EQZ: begin mul_a = mag64(z_reg); mul_b = mag64(z_reg); end
            OP_TX:  begin mul_a = mag64(x_reg); mul_b = t_reg; end
            OP_TY:  begin mul_a = mag64(y_reg); mul_b = t_reg; end
            OP_TZ:  begin mul_a = mag64(z_reg); mul_b = t_reg; end
            OP_TDR: begin mul_a = dr_reg;       mul_b = t_reg; end
            OP_SX:  begin mul_a = ascale_reg;   mul_b = mag64(x_reg); end
            OP_SY:  begin mul_a = ascale_reg;   mul_b = mag64(y_reg); end
            OP_SZ:  begin mul_a = ascale_reg;   mul_b = mag64(z_reg); end
            OP_SDR: begin mul_a = dr_reg;       mul_b = ascale_reg; end
            default: ;
        endcase
    end

    assign div_num = cmd.div_dist ? sq_res_reg << ((SW'(FRACTION_BITS) - s_reg) >> 1)
                                  : ONE;
    assign div_den = cmd.div_dist ? dr_reg : r2_reg;

    assign m       = (mul_res > LIM61) ? LIM61 : mul_res;
    assign m_s     = $signed(m);
    assign dr4     = dr_reg << 2;
    assign sdr_sum = mul_res + ONE;
    assign sq_sum  = sq_res_reg + sq_bit_reg;

    always_comb begin
        sts.mul_done   = mul_done;
        sts.div_done   = div_done;
        sts.lt_quarter = r2_reg < QUARTER;
        sts.lt_one     = r2_reg < ONE;
        sts.gt_esc     = r2_reg > ESC_LIM;
        sts.shift_more = (s_reg >= SW'(2)) && ((r2_reg >> (7'd64 - 7'(s_reg))) != 64'd0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg     <= 64'(in_beat.point_x);
            cy_reg     <= 64'(in_beat.point_y);
            cz_reg     <= 64'(in_beat.point_z);
            x_reg      <= 64'(in_beat.point_x);
            y_reg      <= 64'(in_beat.point_y);
            z_reg      <= 64'(in_beat.point_z);
            scale_reg  <= 64'(fold_scale);
            ascale_reg <= mag64(64'(fold_scale));
            dr_reg     <= ONE;
            sat_reg    <= 1'b0;
            esc_reg    <= 1'b0;
            s_reg      <= SW'(FRACTION_BITS);
        end
        if (cmd.fold) begin
            x_reg <= box(x_reg);
            y_reg <= box(y_reg);
            z_reg <= box(z_reg);
        end
        if (cmd.quad) begin
            x_reg <= x_reg <<< 2;
            y_reg <= y_reg <<< 2;
            z_reg <= z_reg <<< 2;
            if (dr4 > DR_MAX) begin
                dr_reg  <= DR_MAX;
                sat_reg <= 1'b1;
            end else begin
                dr_reg <= dr4;
            end
        end
        if (cmd.mul_wb) begin
            case (cmd.op) inside
                OP_SQX, OP_EQX: r2_reg <= m;
                OP_SQY, OP_EQY, OP_SQZ, OP_EQZ: r2_reg <= r2_reg + m;
                OP_TX: x_reg <= x_reg[63] ? -m_s : m_s;
                OP_TY: y_reg <= y_reg[63] ? -m_s : m_s;
                OP_TZ: z_reg <= z_reg[63] ? -m_s : m_s;
                OP_SX: x_reg <= ((scale_reg[63] ^ x_reg[63]) ? -m_s : m_s) + cx_reg;
                OP_SY: y_reg <= ((scale_reg[63] ^ y_reg[63]) ? -m_s : m_s) + cy_reg;
                OP_SZ: z_reg <= ((scale_reg[63] ^ z_reg[63]) ? -m_s : m_s) + cz_reg;
                OP_TDR: begin
                    if (mul_res > DR_MAX) begin
                        dr_reg  <= DR_MAX;
                        sat_reg <= 1'b1;
                    end else begin
                        dr_reg <= mul_res;
                    end
                end
                OP_SDR: begin
                    // saturated product stays clamped; otherwise add 1.0 then clamp
                    if (mul_res > DR_MAX || sdr_sum > DR_MAX) begin
                        dr_reg  <= DR_MAX;
                        sat_reg <= 1'b1;
                    end else begin
                        dr_reg <= sdr_sum;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.t_wb)    t_reg   <= div_q;
        if (cmd.esc_set) esc_reg <= 1'b1;
        if (cmd.s_dec)   s_reg   <= s_reg - SW'(2);
        if (cmd.sqrt_init) begin
            sq_v_reg   <= r2_reg << s_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= 64'(1) << 62;
        end
        if (cmd.sqrt_step) begin
            if (sq_v_reg >= sq_sum) begin
                sq_v_reg   <= sq_v_reg - sq_sum;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.out_load) begin
            out_reg.distance             <= div_over ? DIST_MAX[DIST_W-1:0]
                                                     : div_q[DIST_W-1:0];
            out_reg.escaped              <= esc_reg;
            out_reg.derivative_saturated <= sat_reg;
        end
    end

    assign out_beat = out_reg;

endmodule

// ===== src/mde_ctrl.sv =====
module mde_ctrl #(
    parameter int MAX_ITERATIONS = mde_pkg::MAX_ITERATIONS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  logic [mde_pkg::LIMIT_W-1:0]   iteration_limit,
    input  mde_pkg::sts_t                 sts,
    output mde_pkg::cmd_t                 cmd
);
    import mde_pkg::*;

    localparam int IW = $clog2(MAX_ITERATIONS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FOLD, ST_MUL_GO, ST_MUL_WAIT, ST_SPHERE, ST_DIV_T,
        ST_CHECK, ST_SHIFT, ST_SQRT, ST_DIV_GO, ST_DIV_D, ST_OUT
    } state_t;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;
    logic [IW-1:0] iter_reg, iter_next, n_reg, n_next;
    logic [4:0] sq_cnt_reg, sq_cnt_next;
    logic valid_reg, valid_next;
    logic [31:0] lim32;

    assign lim32   = 32'(iteration_limit);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = valid_reg;

    always_comb begin
        cmd         = '0;
        cmd.op      = op_reg;
        state_next  = state_reg;
        op_next     = op_reg;
        iter_next   = iter_reg;
        n_next      = n_reg;
        sq_cnt_next = sq_cnt_reg;
        valid_next  = valid_reg & ~m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    iter_next  = '0;
                    if (lim32 < 32'd2) n_next = IW'(2);
                    else if (lim32 > 32'(MAX_ITERATIONS)) n_next = IW'(MAX_ITERATIONS);
                    else n_next = IW'(lim32);
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                op_next    = OP_SQX;
                state_next = ST_MUL_GO;
            end
            ST_MUL_GO: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (sts.mul_done) begin
                    cmd.mul_wb = 1'b1;
                    state_next = ST_MUL_GO;
                    unique case (op_reg)
                        OP_SQX: op_next = OP_SQY;
                        OP_SQY: op_next = OP_SQZ;
                        OP_SQZ: state_next = ST_SPHERE;
                        OP_TX:  op_next = OP_TY;
                        OP_TY:  op_next = OP_TZ;
                        OP_TZ:  op_next = OP_TDR;
                        OP_TDR: op_next = OP_SX;
                        OP_SX:  op_next = OP_SY;
                        OP_SY:  op_next = OP_SZ;
                        OP_SZ:  op_next = OP_SDR;
                        OP_SDR: op_next = OP_EQX;
                        OP_EQX: op_next = OP_EQY;
                        OP_EQY: op_next = OP_EQZ;
                        OP_EQZ: state_next = ST_CHECK;
                        default: state_next = ST_CHECK;
                    endcase
                end
            end
            ST_SPHERE: begin
                op_next    = OP_SX;
                state_next = ST_MUL_GO;
                if (sts.lt_quarter) begin
                    cmd.quad = 1'b1;
                end else if (sts.lt_one) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_T;
                end
            end
            ST_DIV_T: begin
                if (sts.div_done) begin
                    cmd.t_wb   = 1'b1;
                    op_next    = OP_TX;
                    state_next = ST_MUL_GO;
                end
            end
            ST_CHECK: begin
                if (sts.gt_esc) begin
                    cmd.esc_set = 1'b1;
                    state_next  = ST_SHIFT;
                end else if (iter_reg == n_reg - IW'(1)) begin
                    state_next = ST_SHIFT;
                end else begin
                    iter_next  = iter_reg + IW'(1);
                    state_next = ST_FOLD;
                end
            end
            ST_SHIFT: begin
                if (sts.shift_more) begin
                    cmd.s_dec = 1'b1;
                end else begin
                    cmd.sqrt_init = 1'b1;
                    sq_cnt_next   = '0;
                    state_next    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                sq_cnt_next   = sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'(SQRT_STEPS - 1)) state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_dist  = 1'b1;
                state_next    = ST_DIV_D;
            end
            ST_DIV_D: begin
                cmd.div_dist = 1'b1;
                if (sts.div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_SQX;
            iter_reg   <= '0;
            n_reg      <= IW'(2);
            sq_cnt_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            iter_reg   <= iter_next;
            n_reg      <= n_next;
            sq_cnt_reg <= sq_cnt_next;
            valid_reg  <= valid_next;
        end
    end

endmodule

// ===== src/mandelbox_distance_estimate_top.sv =====
// Mandelbox distance estimator, signed Q5.18 fixed point by default.
// Input channel s_*: one beat carries a point (point_x, point_y, point_z).
// Result channel m_*: one beat per point with distance, escaped and
// derivative_saturated. Both use valid/ready; a beat moves when both are high.
// Config port cfg_*: write fold_scale (index 0) or iteration_limit (index 1)
// while no point is in flight; writes take effect at once, no read-back.
// One point at a time: s_ready is high only while the engine is idle.
// Work per fold pass: 10 multiplies on one shared 32x32 multiplier, 14 in
// the middle shell (each is issued, runs 4 partial products and is written
// back), plus a reciprocal divide in the middle shell. A point runs
// iteration_limit passes, clamped to 2..MAX_ITERATIONS, fewer if it escapes,
// then an end phase (up to FRACTION_BITS/2+1 range steps, 32 root steps and
// a final divide).
// A finished result sits in the output register; the next point is accepted
// while it waits, and the engine holds at its end until m_ready frees it.
// Reset (aresetn low, synchronous) empties the engine and output register
// and restores fold_scale = -1.8 and iteration_limit = 12.
module mandelbox_distance_estimate_top #(
    parameter int MAX_ITERATIONS = mde_pkg::MAX_ITERATIONS_DEF,
    parameter int FRACTION_BITS  = mde_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  mde_pkg::in_beat_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output mde_pkg::out_beat_t                   m_data,
    input  logic                                 cfg_we,
    input  logic [mde_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mde_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import mde_pkg::*;

    logic signed [SCALE_W-1:0] fold_scale_reg;
    logic [LIMIT_W-1:0]        iteration_limit_reg;
    cmd_t cmd;
    sts_t sts;

    // config registers; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_scale_reg      <= FOLD_SCALE_RESET;
            iteration_limit_reg <= ITERATION_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FOLD_SCALE:      fold_scale_reg      <= $signed(cfg_wdata[SCALE_W-1:0]);
                REG_ITERATION_LIMIT: iteration_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: walks the fold pass, root and final divide
    mde_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .iteration_limit(iteration_limit_reg),
        .sts(sts), .cmd(cmd)
    );

    // point state, derivative, shared multiplier and divider, output register
    mde_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts),
        .in_beat(s_data), .fold_scale(fold_scale_reg),
        .out_beat(m_data)
    );

endmodule

// ===== src/mde_checker.sv =====
module mde_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input mde_pkg::out_beat_t m_data
);
    import mde_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one point in flight: accepting a beat closes the input
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input open right after an accepted beat");

    // a result comes only at the end of the sequence: none can appear the cycle after accept
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared right after accept");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not idle after reset");

endmodule

bind mandelbox_distance_estimate_top mde_checker u_mde_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_data(m_data)
);
